@@ rtl/core/svfc_pkg.sv @@
// ----------------------------------------------------------------------------
// svfc_pkg
// Shared types and constants for the sorted value frequency counter.
// ----------------------------------------------------------------------------
package svfc_pkg;

  localparam int unsigned DEF_LIST_DEPTH = 32;
  localparam int unsigned DEF_VALUE_BITS = 16;

  localparam int unsigned IN_VALUE_W  = 16;
  localparam int unsigned OUT_INDEX_W = 5;
  localparam int unsigned OUT_COUNT_W = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } svfc_state_e;

endpackage

@@ rtl/core/svfc_intf.sv @@
// ----------------------------------------------------------------------------
// svfc interfaces
// Valid/ready channels for list values and frequency results.
// ----------------------------------------------------------------------------
interface svfc_in_if;
  logic                               valid;
  logic                               ready;
  logic [svfc_pkg::IN_VALUE_W-1:0]    value;
  logic                               last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface svfc_out_if;
  logic                               valid;
  logic                               ready;
  logic [svfc_pkg::OUT_INDEX_W-1:0]   first_index;
  logic [svfc_pkg::OUT_COUNT_W-1:0]   occurrences;
  logic                               overflow;
  logic                               last_result;

  modport source (output valid, output first_index, output occurrences,
                  output overflow, output last_result, input ready);
  modport sink   (input valid, input first_index, input occurrences,
                  input overflow, input last_result, output ready);
endinterface

@@ rtl/core/sorted_value_frequency_count_top.sv @@
// ----------------------------------------------------------------------------
// sorted_value_frequency_count_top
// Counts how often each value of a list occurs, reporting in value order.
// ----------------------------------------------------------------------------
// Values are taken one per cycle while loading; each enters a chain of
// LIST_DEPTH sorting cells and moves right one cell per cycle until it merges
// with an equal value or takes its place in order. After the transaction
// marked last_item the chain settles in ST_SETTLE, then emits one result
// per cycle while out_o.ready is high (smallest value first) from the head
// cell as the chain shifts left. A new list is accepted once the final
// result has been taken. Values beyond LIST_DEPTH per list are dropped and
// flagged as overflow on every result of that list.
module sorted_value_frequency_count_top #(
  parameter int unsigned LIST_DEPTH = svfc_pkg::DEF_LIST_DEPTH,
  parameter int unsigned VALUE_BITS = svfc_pkg::DEF_VALUE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svfc_in_if.sink     in_i,
  svfc_out_if.source  out_o
);

  localparam int unsigned INDEX_W = $clog2(LIST_DEPTH);
  localparam int unsigned COUNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ARRIV_W = $clog2(LIST_DEPTH + 1);

  svfc_pkg::svfc_state_e state_q, state_d;
  logic [ARRIV_W-1:0]    arrival_q, arrival_d;
  logic [ARRIV_W-1:0]    settle_q, settle_d;
  logic                  dropped_q, dropped_d;

  logic                  in_fire, out_fire, shift, store_full;
  logic [VALUE_BITS+svfc_pkg::IN_VALUE_W-1:0] value_ext;

  logic                  ent_valid [LIST_DEPTH+1];
  logic [VALUE_BITS-1:0] ent_value [LIST_DEPTH+1];
  logic [INDEX_W-1:0]    ent_index [LIST_DEPTH+1];
  logic [COUNT_W-1:0]    ent_count [LIST_DEPTH+1];
  logic                  tok_valid [LIST_DEPTH+1];
  logic [VALUE_BITS-1:0] tok_value [LIST_DEPTH+1];
  logic [INDEX_W-1:0]    tok_index [LIST_DEPTH+1];
  logic [COUNT_W-1:0]    tok_count [LIST_DEPTH+1];

  logic [INDEX_W+svfc_pkg::OUT_INDEX_W-1:0] index_ext;
  logic [COUNT_W+svfc_pkg::OUT_COUNT_W-1:0] count_ext;

  assign in_i.ready = (state_q == svfc_pkg::ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign shift      = out_fire;
  assign store_full = (arrival_q == ARRIV_W'(LIST_DEPTH));

  assign value_ext    = {{VALUE_BITS{1'b0}}, in_i.value};
  assign tok_valid[0] = in_fire && !store_full;
  assign tok_value[0] = value_ext[VALUE_BITS-1:0];
  assign tok_index[0] = arrival_q[INDEX_W-1:0];
  assign tok_count[0] = COUNT_W'(1);

  assign ent_valid[LIST_DEPTH] = 1'b0;
  assign ent_value[LIST_DEPTH] = '0;
  assign ent_index[LIST_DEPTH] = '0;
  assign ent_count[LIST_DEPTH] = '0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    svfc_cell #(
      .VALUE_BITS (VALUE_BITS),
      .INDEX_W    (INDEX_W),
      .COUNT_W    (COUNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .tok_valid_i (tok_valid[g]),
      .tok_value_i (tok_value[g]),
      .tok_index_i (tok_index[g]),
      .tok_count_i (tok_count[g]),
      .nbr_valid_i (ent_valid[g+1]),
      .nbr_value_i (ent_value[g+1]),
      .nbr_index_i (ent_index[g+1]),
      .nbr_count_i (ent_count[g+1]),
      .ent_valid_o (ent_valid[g]),
      .ent_value_o (ent_value[g]),
      .ent_index_o (ent_index[g]),
      .ent_count_o (ent_count[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_value_o (tok_value[g+1]),
      .tok_index_o (tok_index[g+1]),
      .tok_count_o (tok_count[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    arrival_d = arrival_q;
    settle_d  = settle_q;
    dropped_d = dropped_q;
    case (state_q)
      svfc_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (store_full) begin
            dropped_d = 1'b1;
          end else begin
            arrival_d = arrival_q + ARRIV_W'(1);
          end
          if (in_i.last_item) begin
            state_d  = svfc_pkg::ST_SETTLE;
            settle_d = '0;
          end
        end
      end
      svfc_pkg::ST_SETTLE: begin
        settle_d = settle_q + ARRIV_W'(1);
        if (settle_q == ARRIV_W'(LIST_DEPTH - 1)) begin
          state_d = svfc_pkg::ST_DRAIN;
        end
      end
      svfc_pkg::ST_DRAIN: begin
        if (out_fire && out_o.last_result) begin
          state_d   = svfc_pkg::ST_LOAD;
          arrival_d = '0;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = svfc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= svfc_pkg::ST_LOAD;
      arrival_q <= '0;
      settle_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      arrival_q <= arrival_d;
      settle_q  <= settle_d;
      dropped_q <= dropped_d;
    end
  end

  assign index_ext = {{svfc_pkg::OUT_INDEX_W{1'b0}}, ent_index[0]};
  assign count_ext = {{svfc_pkg::OUT_COUNT_W{1'b0}}, ent_count[0]};

  assign out_o.valid       = (state_q == svfc_pkg::ST_DRAIN);
  assign out_o.first_index = index_ext[svfc_pkg::OUT_INDEX_W-1:0];
  assign out_o.occurrences = count_ext[svfc_pkg::OUT_COUNT_W-1:0];
  assign out_o.overflow    = dropped_q;
  assign out_o.last_result = !ent_valid[1];

endmodule

@@ rtl/core/svfc_cell.sv @@
// ----------------------------------------------------------------------------
// svfc_cell
// One slot of the sorted chain: holds a distinct value with its first index
// and count, and passes a token (new or displaced entry) to its right.
// ----------------------------------------------------------------------------
module svfc_cell #(
  parameter int unsigned VALUE_BITS = svfc_pkg::DEF_VALUE_BITS,
  parameter int unsigned INDEX_W    = svfc_pkg::OUT_INDEX_W,
  parameter int unsigned COUNT_W    = svfc_pkg::OUT_COUNT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  tok_valid_i,
  input  logic [VALUE_BITS-1:0] tok_value_i,
  input  logic [INDEX_W-1:0]    tok_index_i,
  input  logic [COUNT_W-1:0]    tok_count_i,
  input  logic                  nbr_valid_i,
  input  logic [VALUE_BITS-1:0] nbr_value_i,
  input  logic [INDEX_W-1:0]    nbr_index_i,
  input  logic [COUNT_W-1:0]    nbr_count_i,
  output logic                  ent_valid_o,
  output logic [VALUE_BITS-1:0] ent_value_o,
  output logic [INDEX_W-1:0]    ent_index_o,
  output logic [COUNT_W-1:0]    ent_count_o,
  output logic                  tok_valid_o,
  output logic [VALUE_BITS-1:0] tok_value_o,
  output logic [INDEX_W-1:0]    tok_index_o,
  output logic [COUNT_W-1:0]    tok_count_o
);

  logic                  ent_valid_q, ent_valid_d;
  logic [VALUE_BITS-1:0] ent_value_q, ent_value_d;
  logic [INDEX_W-1:0]    ent_index_q, ent_index_d;
  logic [COUNT_W-1:0]    ent_count_q, ent_count_d;
  logic                  tok_valid_q, tok_valid_d;
  logic [VALUE_BITS-1:0] tok_value_q, tok_value_d;
  logic [INDEX_W-1:0]    tok_index_q, tok_index_d;
  logic [COUNT_W-1:0]    tok_count_q, tok_count_d;

  always_comb begin
    ent_valid_d = ent_valid_q;
    ent_value_d = ent_value_q;
    ent_index_d = ent_index_q;
    ent_count_d = ent_count_q;
    tok_valid_d = 1'b0;
    tok_value_d = tok_value_i;
    tok_index_d = tok_index_i;
    tok_count_d = tok_count_i;
    if (shift_i) begin
      ent_valid_d = nbr_valid_i;
      ent_value_d = nbr_value_i;
      ent_index_d = nbr_index_i;
      ent_count_d = nbr_count_i;
    end else if (tok_valid_i) begin
      if (!ent_valid_q) begin
        ent_valid_d = 1'b1;
        ent_value_d = tok_value_i;
        ent_index_d = tok_index_i;
        ent_count_d = tok_count_i;
      end else if (ent_value_q == tok_value_i) begin
        ent_count_d = ent_count_q + tok_count_i;
      end else if (ent_value_q < tok_value_i) begin
        tok_valid_d = 1'b1;
      end else begin
        // smaller value takes the slot, resident entry moves right
        ent_value_d = tok_value_i;
        ent_index_d = tok_index_i;
        ent_count_d = tok_count_i;
        tok_valid_d = 1'b1;
        tok_value_d = ent_value_q;
        tok_index_d = ent_index_q;
        tok_count_d = ent_count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      ent_valid_q <= ent_valid_d;
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_value_q <= ent_value_d;
    ent_index_q <= ent_index_d;
    ent_count_q <= ent_count_d;
    tok_value_q <= tok_value_d;
    tok_index_q <= tok_index_d;
    tok_count_q <= tok_count_d;
  end

  assign ent_valid_o = ent_valid_q;
  assign ent_value_o = ent_value_q;
  assign ent_index_o = ent_index_q;
  assign ent_count_o = ent_count_q;
  assign tok_valid_o = tok_valid_q;
  assign tok_value_o = tok_value_q;
  assign tok_index_o = tok_index_q;
  assign tok_count_o = tok_count_q;

endmodule

@@ tb/sorted_value_frequency_count_top_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_value_frequency_count_top_tb
// Self-checking bench for the sorted value frequency counter. Lists of values
// are streamed in, and a scoreboard keeps its own sorted table of distinct
// values, first arrival indices and counts. Each result transaction is
// checked in order against that table. The run covers full and overflowing
// lists and varies the idle gaps on both channels.
// ----------------------------------------------------------------------------
module sorted_value_frequency_count_top_tb;

  localparam int unsigned IN_VALUE_W  = svfc_pkg::IN_VALUE_W;
  localparam int unsigned OUT_INDEX_W = svfc_pkg::OUT_INDEX_W;
  localparam int unsigned OUT_COUNT_W = svfc_pkg::OUT_COUNT_W;
  localparam int unsigned DEPTH       = svfc_pkg::DEF_LIST_DEPTH;
  localparam int unsigned VBITS       = svfc_pkg::DEF_VALUE_BITS;
  localparam int unsigned RAND_ITEMS  = 160;
  localparam int unsigned DRAIN_WAIT  = DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int unsigned {
    MODE_NARROW,
    MODE_WIDE,
    MODE_EXTREME,
    MODE_SAME
  } value_mode_e;

  typedef enum int unsigned {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] first_index;
    logic [OUT_COUNT_W-1:0] occurrences;
    logic                   overflow;
    logic                   last_result;
  } freq_result_t;

  class freq_scoreboard;
    logic [IN_VALUE_W-1:0] keys[$];
    int unsigned           first_seen[$];
    int unsigned           tally[$];
    int unsigned           arrivals = 0;
    bit                    dropped = 1'b0;
    freq_result_t          expected_q[$];
    int unsigned           errors = 0;

    function void note_value(logic [IN_VALUE_W-1:0] raw, logic last);
      logic [IN_VALUE_W-1:0] v;
      int unsigned           pos;
      freq_result_t          r;
      v = raw & IN_VALUE_W'((64'd1 << VBITS) - 1);
      if (arrivals < DEPTH) begin
        pos = 0;
        while (pos < keys.size() && keys[pos] < v) pos++;
        if (pos < keys.size() && keys[pos] == v) begin
          tally[pos]++;
        end else if (keys.size() < DEPTH) begin
          keys.insert(pos, v);
          first_seen.insert(pos, arrivals);
          tally.insert(pos, 1);
        end
        arrivals++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        foreach (keys[k]) begin
          r.first_index = OUT_INDEX_W'(first_seen[k]);
          r.occurrences = OUT_COUNT_W'(tally[k]);
          r.overflow    = dropped;
          r.last_result = (k == keys.size() - 1);
          expected_q.insert(expected_q.size(), r);
        end
        keys.delete();
        first_seen.delete();
        tally.delete();
        arrivals = 0;
        dropped  = 1'b0;
      end
    endfunction

    function void check_result(freq_result_t got);
      freq_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: idx=%0d cnt=%0d ovf=%0b last=%0b",
                   got.first_index, got.occurrences, got.overflow, got.last_result);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"mismatch: exp idx=%0d cnt=%0d ovf=%0b last=%0b,",
                    " got idx=%0d cnt=%0d ovf=%0b last=%0b"},
                   want.first_index, want.occurrences, want.overflow, want.last_result,
                   got.first_index, got.occurrences, got.overflow, got.last_result);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  svfc_in_if  in_if ();
  svfc_out_if out_if ();

  sorted_value_frequency_count_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  freq_scoreboard sb = new;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned rand_sent     = 0;
  int unsigned cycles        = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void set_phase(idle_phase_e ph);
    case (ph)
      PH_STEADY:     begin send_idle_pct = 0;  stall_pct = 0;  end
      PH_SEND_IDLE:  begin send_idle_pct = 49; stall_pct = 0;  end
      PH_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 49; end
      default:       begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endfunction

  // result side: sample the handshake, then pick next ready
  initial begin
    freq_result_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.first_index = out_if.first_index;
        got.occurrences = out_if.occurrences;
        got.overflow    = out_if.overflow;
        got.last_result = out_if.last_result;
        sb.check_result(got);
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [IN_VALUE_W-1:0] v, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= v;
    in_if.last_item <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_value(v, last);
  endtask

  task automatic send_list(input int unsigned len, input value_mode_e mode);
    logic [IN_VALUE_W-1:0] base;
    logic [IN_VALUE_W-1:0] v;
    base = IN_VALUE_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        MODE_NARROW: v = base + IN_VALUE_W'($urandom_range(0, 5));
        MODE_WIDE:   v = IN_VALUE_W'($urandom);
        MODE_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            2:       v = {{(IN_VALUE_W-1){1'b1}}, 1'b0};
            default: v = IN_VALUE_W'(1);
          endcase
        end
        default:     v = base;
      endcase
      send_item(v, i == len - 1);
      rand_sent++;
    end
  endtask

  initial begin
    int unsigned list_no;
    value_mode_e mode;
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.last_item <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_phase(PH_STEADY);

    // directed lists: extremes, duplicates, descending and ascending order
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'h0000, 1'b1);
    repeat (4) send_item(16'h0007, 1'b0);
    send_item(16'h0007, 1'b1);
    send_item(16'd40, 1'b0);
    send_item(16'd30, 1'b0);
    send_item(16'd20, 1'b0);
    send_item(16'd10, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b1);

    // hold off until the directed results have all come back
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    list_no = 0;
    while (rand_sent < RAND_ITEMS) begin
      set_phase(idle_phase_e'((list_no / 2) % 4));
      mode = value_mode_e'($urandom_range(0, 3));
      if (list_no == 1)
        send_list(DEPTH, MODE_WIDE);
      else if (list_no == 2)
        send_list(DEPTH + 1, MODE_SAME);
      else if ($urandom_range(0, 9) == 0)
        send_list($urandom_range(DEPTH - 2, DEPTH + 8), mode);
      else
        send_list($urandom_range(1, 10), mode);
      list_no++;
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/svfc_pkg.sv
rtl/core/svfc_intf.sv
rtl/core/svfc_cell.sv
rtl/core/sorted_value_frequency_count_top.sv
tb/sorted_value_frequency_count_top_tb.sv
